FILE: hw/rtl/itmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itmp_pkg: shared types and constants
// Hilbert coefficients, register indexes and filter tap constants.
// ----------------------------------------------------------------------------
package itmp_pkg;

  localparam int TAPS = 31;
  localparam int CENTRE = 15;
  localparam int NCOEF = 8;
  localparam int HILBERT_SHIFT = 15;

  typedef enum logic [1:0] {
    REG_TX_ENABLE = 2'd0,
    REG_DECIM     = 2'd1,
    REG_PHASE_FS  = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  function automatic logic [14:0] coef(input logic [2:0] k);
    logic [14:0] c;
    unique case (k)
      3'd0: c = 15'd97;
      3'd1: c = 15'd267;
      3'd2: c = 15'd572;
      3'd3: c = 15'd1077;
      3'd4: c = 15'd1901;
      3'd5: c = 15'd3330;
      3'd6: c = 15'd6408;
      default: c = 15'd20628;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/itmp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itmp_front: decimation and delay line
// Counts pushed samples for decimation, shifts the delay line and forms the Hilbert pair
// one tap pair a cycle, then pushes (Q, I) into the queue.
// ----------------------------------------------------------------------------
module itmp_front #(
  parameter int SW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [SW-1:0] sample,
  input  wire logic          transmit_enable,
  input  wire logic [3:0]    decim_rate,
  output logic               q_valid,
  input  wire logic          q_ready,
  output logic signed [SW+1:0] q_val,
  output logic signed [SW-1:0] i_val
);

  localparam int AW = SW + 22;

  typedef enum logic [1:0] {S_IDLE, S_ACC, S_OUT} state_t;

  state_t state;
  logic [3:0] decim_count;
  logic [2:0] k;
  logic signed [SW-1:0] delay_line [itmp_pkg::TAPS];
  logic signed [AW-1:0] acc;
  logic signed [SW:0] diff;
  logic signed [AW-1:0] prod;

  assign full = (state != S_IDLE);
  assign diff = {delay_line[2*k][SW-1], delay_line[2*k]}
              - {delay_line[itmp_pkg::TAPS-1-2*k][SW-1], delay_line[itmp_pkg::TAPS-1-2*k]};
  assign prod = AW'(diff) * AW'($signed({1'b0, itmp_pkg::coef(k)}));
  assign q_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      decim_count <= '0;
      k <= '0;
      for (int n = 0; n < itmp_pkg::TAPS; n++) delay_line[n] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push && transmit_enable) begin
            if (4'(decim_count + 4'd1) == decim_rate) begin
              decim_count <= '0;
              for (int n = 0; n < itmp_pkg::TAPS - 1; n++) delay_line[n] <= delay_line[n+1];
              delay_line[itmp_pkg::TAPS-1] <= sample;
              acc <= '0;
              k <= '0;
              state <= S_ACC;
            end else begin
              decim_count <= 4'(decim_count + 4'd1);
            end
          end
        end
        S_ACC: begin
          acc <= acc + prod;
          k <= 3'(k + 3'd1);
          if (k == 3'(itmp_pkg::NCOEF - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (q_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign q_val = (SW+2)'(acc >>> itmp_pkg::HILBERT_SHIFT);
  assign i_val = delay_line[itmp_pkg::CENTRE];

  property p_idle_no_valid;
    @(posedge clk) disable iff (rst) (state == S_IDLE) |-> !q_valid;
  endproperty
  a_idle_no_valid: assert property (p_idle_no_valid) else $error("valid while idle");
  a_count_k: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (k == 3'd0)) else $error("tap index off");
  a_full: assert property (@(posedge clk) disable iff (rst)
    $fell(full) |-> $past(q_ready)) else $error("front freed early");

endmodule
`default_nettype wire

FILE: hw/rtl/itmp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itmp_back: magnitude and phase
// Takes one (Q, I) pair, runs a restoring divider for the ratio, the
// arctangent polynomial, and holds the result until it is popped.
// ----------------------------------------------------------------------------
module itmp_back #(
  parameter int SW = 16,
  parameter int F  = 15
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic signed [SW+1:0] q_val,
  input  wire logic signed [SW-1:0] i_val,
  input  wire logic [15:0]     phase_full_scale,
  output logic                 empty,
  input  wire logic            pop,
  output logic [16:0]          magnitude,
  output logic signed [15:0]   phase
);

  localparam int MW = SW + 1;
  localparam int CW = $clog2(F + 1);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_M1, S_M2, S_FIN, S_OUT} state_t;

  state_t state;
  logic [MW-1:0] hi, rem;
  logic [F:0] z;
  logic [CW-1:0] cnt;
  logic q_neg, i_neg, swap, i_zero;
  logic [15:0] a_c, b_c;
  logic [15:0] t;
  logic [31:0] mul;
  logic [31:0] fs_mul;
  logic [MW:0] rem_sh;
  logic [MW-1:0] aq, ai;

  assign aq = q_val[SW+1] ? MW'(-q_val) : MW'(q_val);
  assign ai = i_val[SW-1] ? MW'(-{i_val[SW-1], i_val}) : MW'({i_val[SW-1], i_val});
  assign rem_sh = (cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign fs_mul = 32'(phase_full_scale) * 32'd47663;
  assign in_ready = (state == S_IDLE);
  assign empty = (state != S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          q_neg <= q_val[SW+1];
          i_neg <= i_val[SW-1];
          i_zero <= (i_val == '0);
          swap <= aq > ai;
          hi <= (aq > ai) ? aq : ai;
          rem <= (aq > ai) ? ai : aq;
          magnitude <= 17'(((aq > ai) ? ai : aq) <= (((aq > ai) ? aq : ai) >> 2)
            ? ((aq > ai) ? aq : ai)
            : (((aq > ai) ? aq : ai) - (((aq > ai) ? aq : ai) >> 3))
              + (((aq > ai) ? ai : aq) >> 1));
          a_c <= 16'((phase_full_scale >> 3) + 16'(fs_mul >> 20));
          b_c <= 16'(fs_mul >> 20);
          z <= '0;
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (hi == '0) begin
            z <= '0;
            state <= S_M1;
          end else begin
            if (rem_sh >= {1'b0, hi}) begin
              rem <= MW'(rem_sh - {1'b0, hi});
              z <= {z[F-1:0], 1'b1};
            end else begin
              rem <= MW'(rem_sh);
              z <= {z[F-1:0], 1'b0};
            end
            cnt <= CW'(cnt + 1'b1);
            if (cnt == CW'(F)) state <= S_M1;
          end
        end
        S_M1: begin
          mul <= 32'(b_c) * 32'(z);
          state <= S_M2;
        end
        S_M2: begin
          t <= 16'(a_c - 16'(mul >> F));
          state <= S_FIN;
        end
        S_FIN: begin
          logic [15:0] at, r;
          at = 16'((48'(t) * 48'(z)) >> F);
          if (swap) r = 16'((phase_full_scale >> 2) - at);
          else r = i_zero ? 16'd0 : at;
          if (i_neg) r = 16'((phase_full_scale >> 1) - r);
          phase <= q_neg ? 16'(-r) : r;
          state <= S_OUT;
        end
        S_OUT: if (pop) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !pop) |=> $stable(phase) && $stable(magnitude))
    else $error("result moved");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && !empty)) else $error("idle and full");
  a_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt <= CW'(F))) else $error("divider overrun");

endmodule
`default_nettype wire

FILE: hw/rtl/iq_to_magnitude_phase_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iq_to_magnitude_phase_top: Hilbert IQ to magnitude and phase
// Decimates samples into a delay line and emits magnitude and phase.
//   channel  | handshake     | payload
//   input    | push / full   | sample
//   result   | empty / pop   | magnitude, phase
//   config   | APB           | transmit_enable, decim_rate, phase_full_scale
// Front: takes no new sample until a kept one's 8 tap pairs are summed and handed on.
// Back: one-bit-a-cycle divider; it takes no new pair until its result is popped.
// A register between the two parts lets the front shift while the back works.
// Reset is synchronous; registers return to 0, 6 and 7352.
// ----------------------------------------------------------------------------
module iq_to_magnitude_phase_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int RATIO_FRAC_BITS = 15
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [SAMPLE_WIDTH-1:0] sample,
  output logic                         empty,
  input  wire logic                    pop,
  output logic [16:0]                  magnitude,
  output logic signed [15:0]           phase,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [3:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic transmit_enable;
  logic [3:0] decim_rate;
  logic [15:0] phase_full_scale;
  logic f_valid, f_ready, h_valid, h_ready;
  logic signed [SAMPLE_WIDTH+1:0] fq, hq;
  logic signed [SAMPLE_WIDTH-1:0] fi, hi;
  itmp_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign idx = itmp_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      transmit_enable <= 1'b0;
      decim_rate <= 4'd6;
      phase_full_scale <= 16'd7352;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        itmp_pkg::REG_TX_ENABLE: transmit_enable <= pwdata[0];
        itmp_pkg::REG_DECIM: decim_rate <= pwdata[3:0];
        itmp_pkg::REG_PHASE_FS: phase_full_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      itmp_pkg::REG_TX_ENABLE: prdata = {31'd0, transmit_enable};
      itmp_pkg::REG_DECIM: prdata = {28'd0, decim_rate};
      itmp_pkg::REG_PHASE_FS: prdata = {16'd0, phase_full_scale};
      default: prdata = '0;
    endcase
  end

  itmp_front #(.SW(SAMPLE_WIDTH)) u_front (
    .clk, .rst, .push, .full, .sample, .transmit_enable, .decim_rate,
    .q_valid(f_valid), .q_ready(f_ready), .q_val(fq), .i_val(fi)
  );

  assign f_ready = !h_valid;

  always_ff @(posedge clk) begin
    if (rst) h_valid <= 1'b0;
    else if (f_valid && f_ready) begin
      h_valid <= 1'b1;
      hq <= fq;
      hi <= fi;
    end else if (h_ready) h_valid <= 1'b0;
  end

  itmp_back #(.SW(SAMPLE_WIDTH), .F(RATIO_FRAC_BITS)) u_back (
    .clk, .rst, .in_valid(h_valid), .in_ready(h_ready), .q_val(hq), .i_val(hi),
    .phase_full_scale, .empty, .pop, .magnitude, .phase
  );

endmodule
`default_nettype wire
